// ----- design/dpc_pkg.sv -----
// Shared constants and the token type for the double dominance pair counter.
package dpc_pkg;

   localparam int MAX_LEN   = 1024;
   localparam int VALUE_W   = 32;
   localparam int HIT_W     = $clog2(MAX_LEN + 1);
   localparam int COUNT_W   = 19;
   localparam int SUM_W     = COUNT_W + 1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // One request travelling down the cell chain.
   typedef struct packed {
      logic                      valid;
      logic                      last;
      logic                      placed;
      logic signed [VALUE_W-1:0] value;
      logic [HIT_W-1:0]          hits;
   } token_type;

endpackage

// ----- design/double_dominance_pair_counter.sv -----
// Top level of the double dominance pair counter: request port, cell chain and tail.
//
// Usage: a request is accepted at a rising edge where start is high and busy is
// low. Each request carries one signed 32-bit value and a last flag. busy is
// always low, so a new request may be given in every cycle.
// Every request walks down a chain of MAX_LEN cells, one cell per cycle. A
// cell that holds an earlier value of the same sequence tests 2*stored <= value
// and adds its hit to the request's tally; the first free cell keeps the value.
// A request marked last empties each cell as it passes, so the next sequence
// can follow directly behind it.
// A request that finds no free cell is dropped and raises the overflow flag.
// The result of a last request appears on rsp_pair_count and rsp_overflow,
// marked by rsp_valid, and stands for one cycle; it is registered in each of
// the MAX_LEN cells of the chain and then once more in the tail.
// Throughput: one request per cycle, sustained.
// The receiver cannot stall: the result stands for exactly one cycle.
// Reset clears all cell full flags, the running count and the overflow flag,
// and drops every request still in the chain.
module double_dominance_pair_counter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [dpc_pkg::VALUE_W-1:0]   req_value,
   input  logic                          req_last,
   output logic                          rsp_valid,
   output logic [dpc_pkg::COUNT_W-1:0]   rsp_pair_count,
   output logic                          rsp_overflow
);
   import dpc_pkg::*;

   // tok[k] enters cell k; tok[MAX_LEN] leaves the chain into the tail.
   token_type tok [0:MAX_LEN];

   // The chain moves every cycle, so the request port never needs to hold off.
   assign busy = 1'b0;

   always_comb begin
      tok[0].valid  = start && !busy;
      tok[0].last   = req_last;
      tok[0].placed = 1'b0;
      tok[0].value  = $signed(req_value);
      tok[0].hits   = '0;
   end

   for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
      dpc_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (tok[k]),
         .tok_out (tok[k+1])
      );
   end

   dpc_accum u_accum (
      .clock          (clock),
      .reset          (reset),
      .tok            (tok[MAX_LEN]),
      .rsp_valid      (rsp_valid),
      .rsp_pair_count (rsp_pair_count),
      .rsp_overflow   (rsp_overflow)
   );

endmodule

// ----- design/dpc_cell.sv -----
// One storage cell of the chain: holds one value and tests passing requests against it.
module dpc_cell (
   input  logic               clock,
   input  logic               reset,
   input  dpc_pkg::token_type tok_in,
   output dpc_pkg::token_type tok_out
);
   import dpc_pkg::*;

   logic signed [VALUE_W-1:0] slot_ff, slot_in;
   logic                      full_ff, full_in;
   token_type                 tok_ff, tok_in_next;
   logic                      hit;

   // 2*stored <= value, both sides taken one bit wider so nothing overflows.
   assign hit = full_ff && ($signed({slot_ff, 1'b0}) <= $signed({tok_in.value[VALUE_W-1],
                                                                  tok_in.value}));

   always_comb begin
      slot_in     = slot_ff;
      full_in     = full_ff;
      tok_in_next = tok_in;
      if (tok_in.valid) begin
         tok_in_next.hits   = tok_in.hits + HIT_W'(hit);
         tok_in_next.placed = tok_in.placed || !full_ff;
         if (tok_in.last) begin
            full_in = 1'b0;
         end else if (!full_ff && !tok_in.placed) begin
            full_in = 1'b1;
            slot_in = tok_in.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff      <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         full_ff      <= full_in;
         tok_ff.valid <= tok_in_next.valid;
      end
      slot_ff       <= slot_in;
      tok_ff.last   <= tok_in_next.last;
      tok_ff.placed <= tok_in_next.placed;
      tok_ff.value  <= tok_in_next.value;
      tok_ff.hits   <= tok_in_next.hits;
   end

   assign tok_out = tok_ff;

   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      tok_in.valid && tok_in.last |=> !full_ff)
      else $error("cell still full after end of sequence passed");

   a_store_first_free: assert property (@(posedge clock) disable iff (reset)
      tok_in.valid && !tok_in.last && !tok_in.placed && !full_ff
      |=> full_ff && tok_out.valid && tok_out.placed)
      else $error("free cell did not take an unplaced value");

   a_full_keeps_placed: assert property (@(posedge clock) disable iff (reset)
      tok_in.valid && full_ff |=> tok_out.valid && tok_out.placed == $past(tok_in.placed))
      else $error("full cell changed the placement flag");

endmodule

// ----- design/dpc_accum.sv -----
// Tail of the chain: sums the hits of each request and issues the sequence result.
module dpc_accum (
   input  logic                          clock,
   input  logic                          reset,
   input  dpc_pkg::token_type            tok,
   output logic                          rsp_valid,
   output logic [dpc_pkg::COUNT_W-1:0]   rsp_pair_count,
   output logic                          rsp_overflow
);
   import dpc_pkg::*;

   logic [COUNT_W-1:0] run_ff, run_in;
   logic               ovf_ff, ovf_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_ovf_ff, rsp_ovf_in;
   logic [SUM_W-1:0]   sum;
   logic [COUNT_W-1:0] total;
   logic               ovf_now;

   always_comb begin
      sum     = SUM_W'(run_ff) + (tok.placed ? SUM_W'(tok.hits) : SUM_W'(0));
      total   = (sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : sum[COUNT_W-1:0];
      ovf_now = ovf_ff || !tok.placed;
      run_in       = run_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = 1'b0;
      rsp_count_in = rsp_count_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (tok.valid) begin
         if (tok.last) begin
            rsp_valid_in = 1'b1;
            rsp_count_in = total;
            rsp_ovf_in   = ovf_now;
            run_in       = '0;
            ovf_in       = 1'b0;
         end else begin
            run_in = total;
            ovf_in = ovf_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_ff       <= run_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_count_ff <= rsp_count_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pair_count = rsp_count_ff;
   assign rsp_overflow   = rsp_ovf_ff;

   a_rsp_after_last: assert property (@(posedge clock) disable iff (reset)
      tok.valid && tok.last |=> rsp_valid_ff)
      else $error("end of sequence gave no result");

   a_no_rsp_otherwise: assert property (@(posedge clock) disable iff (reset)
      !(tok.valid && tok.last) |=> !rsp_valid_ff)
      else $error("result without end of sequence");

   a_unplaced_flags: assert property (@(posedge clock) disable iff (reset)
      tok.valid && !tok.placed |=> ovf_ff || (rsp_valid_ff && rsp_ovf_ff))
      else $error("dropped value did not raise overflow");

endmodule
